FILE: rtl/core/qopt_pkg.sv
package qopt_pkg;

    // Field widths fixed by the interface.
    localparam int unsigned PRESCALE_W = 16;
    localparam int unsigned PERIOD_W   = 32;
    localparam int unsigned DELAY_W    = 17;
    localparam int unsigned RELOAD_W   = 16;
    localparam int unsigned KIND_W     = 2;

    // Defaults for the top-level parameters.
    localparam int unsigned RING_SLOTS_DEF = 8;
    localparam int unsigned TAG_BITS_DEF   = 8;

    // Register reset values.
    localparam logic [PRESCALE_W-1:0] PRESCALE_RST = 16'd7999;
    localparam logic [PERIOD_W-1:0]   PERIOD_RST   = 32'd1000;

    // Configuration port.
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic [1:0]  REG_PRESCALE = 2'd0;
    localparam logic [1:0]  REG_PERIOD   = 2'd1;
    localparam logic [1:0]  REG_ENABLE   = 2'd2;

    // Result queue depth, a power of two holding at least two results.
    localparam int unsigned OUTQ_DEPTH = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_PERIODIC = 2'd0,
        KIND_ONESHOT  = 2'd1,
        KIND_DROP     = 2'd2
    } t_kind;

    typedef enum logic {
        S_IDLE,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic [PRESCALE_W-1:0] prescale;
        logic [PERIOD_W-1:0]   period;
        logic                  enable;
        logic                  clear;
    } t_cfg;

    typedef struct packed {
        logic first;
        logic second;
    } t_push;

endpackage

FILE: rtl/core/queued_oneshot_and_periodic_timer.sv
// Two millisecond timers driven by a stream of source clock ticks, sharing one
// prescaler setting. Each input transfer is either one tick (opcode 0) or a
// one-shot request (opcode 1) with a delay in milliseconds and a tag. The
// periodic timer, while enabled, reports event_kind 0 every period. A one-shot
// request starts at once when no one-shot runs; otherwise it waits in a ring
// that holds RING_SLOTS-1 requests, and a request that finds the ring full is
// reported right away as event_kind 2 with its tag. An expiring one-shot is
// reported as event_kind 1 with its tag, and the oldest waiting request then
// starts. A tick may give two results (periodic first); o_last marks the final
// result of each input transfer. Items are normally taken back to back; a
// tick whose expiry starts a queued request holds off the next item while the
// waiting entry is read from the ring RAM, whose read data is registered.
// Results wait in a four-entry queue, and input is taken only while that
// queue has room for two results, so a stalled output side eventually stalls
// the input. Registers live on an APB-style port: prescale_divide at 0x0,
// periodic_period_ms at 0x4, periodic_enable at 0x8; writing 1 to the enable
// restarts the periodic counts. Configuration is meant to be written while
// the block is idle. There is no clearing pass after reset.
module queued_oneshot_and_periodic_timer #(
    parameter int unsigned RING_SLOTS = qopt_pkg::RING_SLOTS_DEF,
    parameter int unsigned TAG_BITS   = qopt_pkg::TAG_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input channel.
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_opcode,
    input  logic [qopt_pkg::DELAY_W-1:0]        i_delay_ms,
    input  logic [TAG_BITS-1:0]                 i_event_tag,
    // Result channel.
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [qopt_pkg::KIND_W-1:0]         o_event_kind,
    output logic [TAG_BITS-1:0]                 o_tag_out,
    output logic                                o_last,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [qopt_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [qopt_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [qopt_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int unsigned PTR_W   = $clog2(RING_SLOTS);
    localparam int unsigned ENTRY_W = TAG_BITS + qopt_pkg::DELAY_W;
    localparam int unsigned RES_W   = qopt_pkg::KIND_W + TAG_BITS + 1;

    logic [qopt_pkg::PRESCALE_W-1:0] r_prescale;
    logic [qopt_pkg::PERIOD_W-1:0]   r_period;
    logic                            r_enable;
    logic                            wr;
    logic [1:0]                      reg_idx;
    qopt_pkg::t_cfg                  cfg;

    qopt_pkg::t_push    push;
    logic [RES_W-1:0]   res0, res1, res_out;
    logic               space2;
    logic               ram_we, ram_re;
    logic [PTR_W-1:0]   ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    // The register file answers every access at once.
    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale <= qopt_pkg::PRESCALE_RST;
            r_period   <= qopt_pkg::PERIOD_RST;
            r_enable   <= 1'b0;
        end else if (wr) begin
            unique case (reg_idx)
                qopt_pkg::REG_PRESCALE: r_prescale <= pwdata[qopt_pkg::PRESCALE_W-1:0];
                qopt_pkg::REG_PERIOD:   r_period   <= pwdata;
                qopt_pkg::REG_ENABLE:   r_enable   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            qopt_pkg::REG_PRESCALE: prdata = {16'b0, r_prescale};
            qopt_pkg::REG_PERIOD:   prdata = r_period;
            qopt_pkg::REG_ENABLE:   prdata = {31'b0, r_enable};
            default:                prdata = '0;
        endcase
    end

    // Enabling the periodic timer restarts it from count zero.
    always_comb begin
        cfg.prescale = r_prescale;
        cfg.period   = r_period;
        cfg.enable   = r_enable;
        cfg.clear    = wr && (reg_idx == qopt_pkg::REG_ENABLE) && pwdata[0];
    end

    qopt_ctrl #(
        .RING_SLOTS (RING_SLOTS),
        .TAG_BITS   (TAG_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_delay_ms  (i_delay_ms),
        .i_event_tag (i_event_tag),
        .i_space2    (space2),
        .o_push      (push),
        .o_res0      (res0),
        .o_res1      (res1),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    // Waiting one-shot requests, {tag, delay} per slot.
    qopt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_SLOTS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    qopt_outq #(
        .WIDTH (RES_W)
    ) u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_res0   (res0),
        .i_res1   (res1),
        .o_space2 (space2),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_res    (res_out)
    );

    assign o_event_kind = res_out[RES_W-1 -: qopt_pkg::KIND_W];
    assign o_tag_out    = res_out[TAG_BITS:1];
    assign o_last       = res_out[0];

endmodule

FILE: rtl/core/qopt_ram.sv
module qopt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/qopt_outq.sv
module qopt_outq #(
    parameter int unsigned WIDTH = 11
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  qopt_pkg::t_push    i_push,
    input  logic [WIDTH-1:0]   i_res0,
    input  logic [WIDTH-1:0]   i_res1,
    output logic               o_space2,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [WIDTH-1:0]   o_res
);

    localparam int unsigned IDX_W = $clog2(qopt_pkg::OUTQ_DEPTH);
    localparam int unsigned CNT_W = $clog2(qopt_pkg::OUTQ_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [qopt_pkg::OUTQ_DEPTH];
    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic             pop;
    logic [IDX_W-1:0] tail_p1;

    assign pop     = o_valid && i_ready;
    assign tail_p1 = r_tail + 1'b1;

    always_comb begin
        n_head  = pop ? r_head + 1'b1 : r_head;
        n_tail  = r_tail;
        n_count = r_count - CNT_W'(pop);
        if (i_push.first) begin
            n_tail  = tail_p1;
            n_count = n_count + 1'b1;
        end
        if (i_push.second) begin
            n_tail  = r_tail + IDX_W'(2);
            n_count = n_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.first) begin
            r_mem[r_tail] <= i_res0;
        end
        if (i_push.second) begin
            r_mem[tail_p1] <= i_res1;
        end
    end

    assign o_space2 = (r_count <= CNT_W'(qopt_pkg::OUTQ_DEPTH - 2));
    assign o_valid  = (r_count != '0);
    assign o_res    = r_mem[r_head];

endmodule

FILE: rtl/core/qopt_ctrl.sv
module qopt_ctrl #(
    parameter int unsigned RING_SLOTS = qopt_pkg::RING_SLOTS_DEF,
    parameter int unsigned TAG_BITS   = qopt_pkg::TAG_BITS_DEF,
    localparam int unsigned PTR_W     = $clog2(RING_SLOTS),
    localparam int unsigned ENTRY_W   = TAG_BITS + qopt_pkg::DELAY_W,
    localparam int unsigned RES_W     = qopt_pkg::KIND_W + TAG_BITS + 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  qopt_pkg::t_cfg                i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_opcode,
    input  logic [qopt_pkg::DELAY_W-1:0]  i_delay_ms,
    input  logic [TAG_BITS-1:0]           i_event_tag,
    input  logic                          i_space2,
    output qopt_pkg::t_push               o_push,
    output logic [RES_W-1:0]              o_res0,
    output logic [RES_W-1:0]              o_res1,
    output logic                          o_ram_we,
    output logic [PTR_W-1:0]              o_ram_waddr,
    output logic [ENTRY_W-1:0]            o_ram_wdata,
    output logic                          o_ram_re,
    output logic [PTR_W-1:0]              o_ram_raddr,
    input  logic [ENTRY_W-1:0]            i_ram_rdata
);

    localparam int unsigned PS_W = qopt_pkg::PRESCALE_W;
    localparam int unsigned PD_W = qopt_pkg::PERIOD_W;
    localparam int unsigned DL_W = qopt_pkg::DELAY_W;
    localparam int unsigned RL_W = qopt_pkg::RELOAD_W;

    qopt_pkg::t_state    r_state, n_state;
    logic [PS_W-1:0]     r_pps, n_pps;
    logic [PD_W-1:0]     r_pms, n_pms;
    logic [PS_W-1:0]     r_ops, n_ops;
    logic [DL_W-1:0]     r_rem, n_rem;
    logic                r_run, n_run;
    logic [TAG_BITS-1:0] r_tag, n_tag;
    logic [PTR_W-1:0]    r_head, n_head;
    logic [PTR_W-1:0]    r_tail, n_tail;

    logic                accept;
    logic                fire, expire, drop;
    logic [PTR_W-1:0]    tail_next;
    logic [PTR_W-1:0]    head_next;
    logic [DL_W-1:0]     start_delay;
    logic [TAG_BITS-1:0] start_tag;
    logic [DL_W-1:0]     start_rem;
    logic [RL_W-1:0]     reload;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_SLOTS - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_ready   = (r_state == qopt_pkg::S_IDLE) && i_space2;
    assign accept    = i_valid && o_ready;
    assign tail_next = ring_next(r_tail);
    assign head_next = ring_next(r_head);

    // A new one-shot takes its delay from the request or from the ring entry.
    always_comb begin
        if (r_state == qopt_pkg::S_LOAD) begin
            start_delay = i_ram_rdata[DL_W-1:0];
            start_tag   = i_ram_rdata[ENTRY_W-1:DL_W];
        end else begin
            start_delay = i_delay_ms;
            start_tag   = i_event_tag;
        end
        // Zero acts as the full 16-bit range; larger values wrap.
        reload    = start_delay[RL_W-1:0] - 1'b1;
        start_rem = {1'b0, reload} + 1'b1;
    end

    always_comb begin
        n_state = r_state;
        n_pps   = r_pps;
        n_pms   = r_pms;
        n_ops   = r_ops;
        n_rem   = r_rem;
        n_run   = r_run;
        n_tag   = r_tag;
        n_head  = r_head;
        n_tail  = r_tail;
        fire    = 1'b0;
        expire  = 1'b0;
        drop    = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_tail;
        o_ram_wdata = {i_event_tag, i_delay_ms};
        o_ram_re    = 1'b0;
        o_ram_raddr = r_head;

        unique case (r_state)
            qopt_pkg::S_LOAD: begin
                n_rem   = start_rem;
                n_tag   = start_tag;
                n_ops   = '0;
                n_run   = 1'b1;
                n_state = qopt_pkg::S_IDLE;
            end
            qopt_pkg::S_IDLE: begin
                if (accept && i_opcode) begin
                    if (!r_run) begin
                        n_rem = start_rem;
                        n_tag = start_tag;
                        n_ops = '0;
                        n_run = 1'b1;
                    end else if (tail_next == r_head) begin
                        drop = 1'b1;
                    end else begin
                        o_ram_we = 1'b1;
                        n_tail   = tail_next;
                    end
                end else if (accept) begin
                    if (i_cfg.enable) begin
                        if (r_pps >= i_cfg.prescale) begin
                            n_pps = '0;
                            if (r_pms >= i_cfg.period - 1'b1) begin
                                n_pms = '0;
                                fire  = 1'b1;
                            end else begin
                                n_pms = r_pms + 1'b1;
                            end
                        end else begin
                            n_pps = r_pps + 1'b1;
                        end
                    end
                    if (r_run) begin
                        if (r_ops >= i_cfg.prescale) begin
                            n_ops = '0;
                            if (r_rem <= DL_W'(1)) begin
                                n_rem  = '0;
                                expire = 1'b1;
                                n_tag  = '0;
                                n_run  = 1'b0;
                                // The next waiting request starts once its
                                // entry has come out of the ring memory.
                                if (r_head != r_tail) begin
                                    o_ram_re = 1'b1;
                                    n_head   = head_next;
                                    n_state  = qopt_pkg::S_LOAD;
                                end
                            end else begin
                                n_rem = r_rem - 1'b1;
                            end
                        end else begin
                            n_ops = r_ops + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = qopt_pkg::S_IDLE;
            end
        endcase

        if (i_cfg.clear) begin
            n_pps = '0;
            n_pms = '0;
        end
    end

    // The periodic result always comes before the one-shot result.
    always_comb begin
        o_push.first  = fire || expire || drop;
        o_push.second = fire && expire;
        if (fire) begin
            o_res0 = {qopt_pkg::KIND_PERIODIC, {TAG_BITS{1'b0}}, !expire};
        end else if (expire) begin
            o_res0 = {qopt_pkg::KIND_ONESHOT, r_tag, 1'b1};
        end else begin
            o_res0 = {qopt_pkg::KIND_DROP, i_event_tag, 1'b1};
        end
        o_res1 = {qopt_pkg::KIND_ONESHOT, r_tag, 1'b1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qopt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pps  <= '0;
            r_pms  <= '0;
            r_ops  <= '0;
            r_rem  <= '0;
            r_run  <= 1'b0;
            r_tag  <= '0;
            r_head <= '0;
            r_tail <= '0;
        end else begin
            r_pps  <= n_pps;
            r_pms  <= n_pms;
            r_ops  <= n_ops;
            r_rem  <= n_rem;
            r_run  <= n_run;
            r_tag  <= n_tag;
            r_head <= n_head;
            r_tail <= n_tail;
        end
    end

endmodule

FILE: rtl/core/qopt_checker.sv
module qopt_checker #(
    parameter int unsigned TAG_BITS = qopt_pkg::TAG_BITS_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [qopt_pkg::KIND_W-1:0] o_event_kind,
    input logic [TAG_BITS-1:0]         o_tag_out,
    input logic                        o_last
);

    // A result held back by the consumer stays as it was.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_event_kind)
            && $stable(o_tag_out) && $stable(o_last))
        else $error("result changed while stalled");

    // The periodic timer carries no tag.
    a_periodic_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_kind == qopt_pkg::KIND_PERIODIC) |-> (o_tag_out == '0))
        else $error("periodic result with a tag");

    // A dropped request is the only result of its input.
    a_drop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_kind == qopt_pkg::KIND_DROP) |-> o_last)
        else $error("drop result not marked last");

    // A periodic result that is not last is followed by the one-shot expiry.
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && (o_event_kind == qopt_pkg::KIND_PERIODIC) && !o_last
            |=> o_valid && (o_event_kind == qopt_pkg::KIND_ONESHOT) && o_last)
        else $error("periodic result without its one-shot partner");

endmodule

bind queued_oneshot_and_periodic_timer qopt_checker #(
    .TAG_BITS (TAG_BITS)
) u_qopt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_event_kind (o_event_kind),
    .o_tag_out    (o_tag_out),
    .o_last       (o_last)
);
